FILE: sv/mjpeg_frame_extractor_macros.svh
// assertion macros shared by the frame extractor modules
`ifndef MJPEG_FRAME_EXTRACTOR_MACROS_SVH
`define MJPEG_FRAME_EXTRACTOR_MACROS_SVH

// property checked on every clock edge outside reset
`define MFE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent in this cycle implies consequent in the next
`define MFE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/mfe_pkg.sv
// shared types and constants of the frame extractor
package mfe_pkg;

  localparam logic [7:0] MARK_LEAD = 8'hff;
  localparam logic [7:0] MARK_SOI  = 8'hd8;
  localparam logic [7:0] MARK_EOI  = 8'hd9;
  localparam int unsigned MIN_FRAME = 4;

  localparam int unsigned ADDR_W = 14;
  localparam int unsigned LEN_W  = 15;
  localparam int unsigned CAP_W  = 15;
  localparam int unsigned CNT_W  = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = 15'd16384;
  localparam logic [CNT_W-1:0] CNT_RESET = 2'd2;

  localparam logic REG_CAPACITY = 1'b0;
  localparam logic REG_COUNT    = 1'b1;

  typedef struct packed {
    logic              soi;
    logic              slot;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
    logic              done;
    logic [LEN_W-1:0]  length;
  } mfe_cmd_t;

endpackage

FILE: sv/mfe_front.sv
// front end: marker detection, slot choice and write commands
`include "mjpeg_frame_extractor_macros.svh"

module mfe_front #(
  parameter int MAX_CAPACITY = 16384
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  logic [7:0]                 data_byte,
  input  logic [1:0]                 busy_slot,
  input  logic [mfe_pkg::CAP_W-1:0]  buffer_capacity,
  input  logic [mfe_pkg::CNT_W-1:0]  buffer_count,
  output logic                       cmd_push,
  output mfe_pkg::mfe_cmd_t          cmd
);
  import mfe_pkg::*;

  localparam logic [16:0] MAX_CAP = 17'(MAX_CAPACITY);
  localparam logic [16:0] MIN_CAP = 17'(MIN_FRAME);

  logic              in_frame, in_frame_next;
  logic              dropping, dropping_next;
  logic              pending_marker, pending_marker_next;
  logic [7:0]        previous_byte, previous_byte_next;
  logic              fill_slot, fill_slot_next;
  logic              current_slot, current_slot_next;
  logic [LEN_W-1:0]  byte_count, byte_count_next;

  logic [16:0]       cap_raw, cap_eff;
  logic              two_bufs;
  logic [1:0]        busy_eff;
  logic              pick;
  logic              slot_free;
  logic [LEN_W-1:0]  count_inc;
  logic              frame_end;
  logic              is_full;

  always_comb begin
    cap_raw = {2'b00, buffer_capacity};
    if (cap_raw < MIN_CAP) begin
      cap_eff = MIN_CAP;
    end else if (cap_raw > MAX_CAP) begin
      cap_eff = MAX_CAP;
    end else begin
      cap_eff = cap_raw;
    end
    two_bufs = buffer_count[1];
    busy_eff = (busy_slot == 2'd3) ? 2'd2 : busy_slot;
    pick = fill_slot;
    if (two_bufs && ({1'b0, pick} == busy_eff)) begin
      pick = ~pick;
    end
    slot_free = ({1'b0, pick} != busy_eff) && (two_bufs || !pick);
    count_inc = byte_count + 1'b1;
    is_full   = {2'b00, byte_count} >= cap_eff;
    frame_end = (count_inc >= LEN_W'(MIN_FRAME)) && (previous_byte == MARK_LEAD)
                && (data_byte == MARK_EOI);
  end

  always_comb begin
    in_frame_next       = in_frame;
    dropping_next       = dropping;
    pending_marker_next = pending_marker;
    previous_byte_next  = previous_byte;
    fill_slot_next      = fill_slot;
    current_slot_next   = current_slot;
    byte_count_next     = byte_count;
    cmd_push            = 1'b0;
    cmd                 = '0;
    if (accept) begin
      if (!in_frame) begin
        if (pending_marker && (data_byte == MARK_SOI)) begin
          pending_marker_next = 1'b0;
          in_frame_next       = 1'b1;
          previous_byte_next  = MARK_SOI;
          if (!slot_free) begin
            dropping_next   = 1'b1;
            byte_count_next = '0;
          end else begin
            dropping_next     = 1'b0;
            current_slot_next = pick;
            byte_count_next   = LEN_W'(2);
            cmd_push          = 1'b1;
            cmd.soi           = 1'b1;
            cmd.slot          = pick;
          end
        end else begin
          pending_marker_next = (data_byte == MARK_LEAD);
        end
      end else if (dropping) begin
        if ((previous_byte == MARK_LEAD) && (data_byte == MARK_EOI)) begin
          in_frame_next   = 1'b0;
          dropping_next   = 1'b0;
          byte_count_next = '0;
        end
        previous_byte_next = data_byte;
      end else if (is_full) begin
        dropping_next      = 1'b1;
        previous_byte_next = data_byte;
      end else begin
        cmd_push           = 1'b1;
        cmd.slot           = current_slot;
        cmd.addr           = byte_count[ADDR_W-1:0];
        cmd.data           = data_byte;
        cmd.done           = frame_end;
        cmd.length         = frame_end ? count_inc : '0;
        byte_count_next    = count_inc;
        previous_byte_next = data_byte;
        if (frame_end) begin
          if (two_bufs) begin
            fill_slot_next = ~current_slot;
          end
          in_frame_next   = 1'b0;
          byte_count_next = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame       <= 1'b0;
      dropping       <= 1'b0;
      pending_marker <= 1'b0;
      previous_byte  <= '0;
      fill_slot      <= 1'b0;
      current_slot   <= 1'b0;
      byte_count     <= '0;
    end else begin
      in_frame       <= in_frame_next;
      dropping       <= dropping_next;
      pending_marker <= pending_marker_next;
      previous_byte  <= previous_byte_next;
      fill_slot      <= fill_slot_next;
      current_slot   <= current_slot_next;
      byte_count     <= byte_count_next;
    end
  end

  `MFE_ASSERT(a_drop_in_frame, !dropping || in_frame, "dropping outside a frame")
  `MFE_ASSERT_NEXT(a_soi_count, cmd_push && cmd.soi, byte_count == LEN_W'(2),
    "start marker did not set count to two")

endmodule

FILE: sv/mfe_fifo.sv
// command queue between front and back
`include "mjpeg_frame_extractor_macros.svh"

module mfe_fifo #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  mfe_pkg::mfe_cmd_t push_data,
  output logic              full,
  input  logic              pop,
  output mfe_pkg::mfe_cmd_t pop_data,
  output logic              empty
);
  import mfe_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  mfe_cmd_t        slots [DEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push, do_pop;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  `MFE_ASSERT(a_no_push_full, !(push && full), "command pushed into a full queue")

endmodule

FILE: sv/mfe_back.sv
// back end: expands commands into result items behind an output register
`include "mjpeg_frame_extractor_macros.svh"

module mfe_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cmd_empty,
  input  mfe_pkg::mfe_cmd_t           cmd,
  output logic                        cmd_pop,
  output logic                        empty,
  input  logic                        pop,
  output logic                        write_valid,
  output logic                        write_slot,
  output logic [mfe_pkg::ADDR_W-1:0]  write_address,
  output logic [7:0]                  write_data,
  output logic                        frame_done,
  output logic                        frame_slot,
  output logic [mfe_pkg::LEN_W-1:0]   frame_length,
  output logic                        last
);
  import mfe_pkg::*;

  typedef enum logic {
    ST_NORMAL,
    ST_SOI_TAIL
  } state_t;

  state_t state;
  logic   out_valid;
  logic   advance;

  assign empty       = !out_valid;
  assign write_valid = 1'b1;
  assign advance     = !out_valid || pop;
  assign cmd_pop     = advance && (state == ST_NORMAL) && !cmd_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_NORMAL;
      out_valid <= 1'b0;
    end else if (advance) begin
      case (state)
        ST_SOI_TAIL: begin
          out_valid     <= 1'b1;
          write_address <= ADDR_W'(1);
          write_data    <= MARK_SOI;
          frame_done    <= 1'b0;
          frame_slot    <= 1'b0;
          frame_length  <= '0;
          last          <= 1'b1;
          state         <= ST_NORMAL;
        end
        ST_NORMAL: begin
          out_valid <= !cmd_empty;
          if (!cmd_empty) begin
            write_slot <= cmd.slot;
            if (cmd.soi) begin
              write_address <= '0;
              write_data    <= MARK_LEAD;
              frame_done    <= 1'b0;
              frame_slot    <= 1'b0;
              frame_length  <= '0;
              last          <= 1'b0;
              state         <= ST_SOI_TAIL;
            end else begin
              write_address <= cmd.addr;
              write_data    <= cmd.data;
              frame_done    <= cmd.done;
              frame_slot    <= cmd.done & cmd.slot;
              frame_length  <= cmd.length;
              last          <= 1'b1;
            end
          end
        end
        default: begin
          state     <= ST_NORMAL;
          out_valid <= 1'b0;
        end
      endcase
    end
  end

  `MFE_ASSERT(a_tail_has_lead, (state != ST_SOI_TAIL) || (out_valid && !last),
    "start marker tail without a waiting lead byte")
  `MFE_ASSERT(a_done_is_last, !(out_valid && frame_done) || last,
    "frame end not on the final item")

endmodule

FILE: sv/mjpeg_frame_extractor.sv
// top level of the MJPEG frame extractor with config registers
//
//  channel   handshake            payload
//  input     push / full          data_byte, busy_slot
//  result    empty / pop          write_*, frame_*, last
//  config    psel/penable/pready  paddr, pwdata, prdata
//
// one input item per cycle while full is low; a start marker yields two
// result items, lead byte then start byte, which the back end emits while
// the front keeps filling the queue; bytes pass the queue and output register
// synchronous reset clears all control state and presets both registers
// full rises only when the command queue holds QUEUE_DEPTH entries
`include "mjpeg_frame_extractor_macros.svh"

module mjpeg_frame_extractor #(
  parameter int MAX_CAPACITY = 16384,
  parameter int QUEUE_DEPTH  = 4
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        push,
  output logic                        full,
  input  logic [7:0]                  data_byte,
  input  logic [1:0]                  busy_slot,
  output logic                        empty,
  input  logic                        pop,
  output logic                        write_valid,
  output logic                        write_slot,
  output logic [mfe_pkg::ADDR_W-1:0]  write_address,
  output logic [7:0]                  write_data,
  output logic                        frame_done,
  output logic                        frame_slot,
  output logic [mfe_pkg::LEN_W-1:0]   frame_length,
  output logic                        last
);
  import mfe_pkg::*;

  logic [CAP_W-1:0] buffer_capacity;
  logic [CNT_W-1:0] buffer_count;
  logic             cfg_write;
  logic             accept;
  logic             cmd_push;
  mfe_cmd_t         cmd_in, cmd_out;
  logic             cmd_empty, cmd_pop;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign accept    = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_capacity <= CAP_RESET;
      buffer_count    <= CNT_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_CAPACITY: buffer_capacity <= pwdata[CAP_W-1:0];
        REG_COUNT:    buffer_count    <= pwdata[CNT_W-1:0];
        default:      buffer_count    <= buffer_count;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_CAPACITY: prdata = {{(32-CAP_W){1'b0}}, buffer_capacity};
      REG_COUNT:    prdata = {{(32-CNT_W){1'b0}}, buffer_count};
      default:      prdata = '0;
    endcase
  end

  mfe_front #(
    .MAX_CAPACITY(MAX_CAPACITY)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .accept          (accept),
    .data_byte       (data_byte),
    .busy_slot       (busy_slot),
    .buffer_capacity (buffer_capacity),
    .buffer_count    (buffer_count),
    .cmd_push        (cmd_push),
    .cmd             (cmd_in)
  );

  mfe_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd_push),
    .push_data (cmd_in),
    .full      (full),
    .pop       (cmd_pop),
    .pop_data  (cmd_out),
    .empty     (cmd_empty)
  );

  mfe_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd_empty     (cmd_empty),
    .cmd           (cmd_out),
    .cmd_pop       (cmd_pop),
    .empty         (empty),
    .pop           (pop),
    .write_valid   (write_valid),
    .write_slot    (write_slot),
    .write_address (write_address),
    .write_data    (write_data),
    .frame_done    (frame_done),
    .frame_slot    (frame_slot),
    .frame_length  (frame_length),
    .last          (last)
  );

  `MFE_ASSERT_NEXT(a_cfg_count, cfg_write && (paddr[2] == REG_COUNT),
    buffer_count == $past(pwdata[CNT_W-1:0]), "count register not written")

endmodule
